@@ rtl/sit_pkg.sv @@
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types and defaults for the sorted insert table: request and
// response payloads, operation codes and the control bundle fed to each cell.
// ----------------------------------------------------------------------------
package sit_pkg;

   // default sizing
   localparam int TableDepthDefault = 16;
   localparam int TagBitsDefault    = 64;

   // fixed field widths
   localparam int ScoreWidth = 16;
   localparam int TagWidth   = 64;
   localparam int RankWidth  = 4;
   localparam int CountWidth = 5;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_READ   = 1'b1
   } op_type;

   // one request
   typedef struct packed {
      op_type                        op;
      logic signed [ScoreWidth-1:0]  score;
      logic [TagWidth-1:0]           tag;
      logic [RankWidth-1:0]          rank_query;
   } req_type;

   // one response
   typedef struct packed {
      logic [CountWidth-1:0]         placed_rank;
      logic                          kept;
      logic                          evicted;
      logic [CountWidth-1:0]         fill_count;
      logic signed [ScoreWidth-1:0]  read_score;
      logic [TagWidth-1:0]           read_tag;
      logic                          read_valid;
   } rsp_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic                          ins_en;
      logic signed [ScoreWidth-1:0]  score;
      logic [TagWidth-1:0]           tag;
   } cell_ctl_type;

endpackage

@@ rtl/sit_cell.sv @@
// ----------------------------------------------------------------------------
// sit_cell
// One rank of the sorted table. Holds a score and a tag, compares its score
// against the incoming one and on an insert either keeps its entry, takes
// the new entry, or takes its left neighbor's entry (shift toward the tail).
// ----------------------------------------------------------------------------
module sit_cell #(
   parameter int TAG_BITS = 64
) (
   input  logic                                 clock,
   input  sit_pkg::cell_ctl_type                ctl,
   input  logic                                 cell_valid,
   input  logic                                 left_ge,
   input  logic signed [sit_pkg::ScoreWidth-1:0] left_score,
   input  logic [TAG_BITS-1:0]                  left_tag,
   output logic                                 ge,
   output logic                                 take_new,
   output logic signed [sit_pkg::ScoreWidth-1:0] score_ff,
   output logic [TAG_BITS-1:0]                  tag_ff
);
   import sit_pkg::*;

   logic signed [ScoreWidth-1:0] score_in;
   logic [TAG_BITS-1:0]          tag_in;

   // stored entry ranks at or above the newcomer
   assign ge       = cell_valid && (score_ff >= ctl.score);
   // boundary: left neighbor stays, this one does not
   assign take_new = !ge && left_ge;

   // next entry
   always_comb begin
      score_in = score_ff;
      tag_in   = tag_ff;
      if (ctl.ins_en && !ge) begin
         if (left_ge) begin
            score_in = ctl.score;
            tag_in   = ctl.tag[TAG_BITS-1:0];
         end else begin
            score_in = left_score;
            tag_in   = left_tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      score_ff <= score_in;
      tag_ff   <= tag_in;
   end

endmodule

@@ rtl/sorted_insert_table_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_insert_table_unit
// Bounded table of entries kept in descending score order, built as a chain
// of cells that shift toward the tail on an insert.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start/req_data and are taken at a clock edge where
//   start is high and busy is low. busy stays low: every cycle can carry a
//   request. An insert (op OP_INSERT) lands after every entry whose score is
//   greater or equal; a full table evicts its last entry, or drops the
//   newcomer if it would rank last. A read (op OP_READ) returns the entry at
//   rank_query, rank 0 being the highest score.
//   Each request gives exactly one response on rsp_data, flagged by
//   rsp_strobe for a single cycle, in the cycle after the request is taken.
//   Throughput is one request per cycle: all cells compare against the new
//   score in parallel and shift in the same edge; the read is a mux over the
//   cells ahead of the response register.
//   The receiver cannot stall; the response must be captured on its strobe.
//   Reset (synchronous, active high) empties the table (fill count zero) and
//   clears the strobe; stored entries are not cleared and are never shown
//   before they are written.
// ----------------------------------------------------------------------------
module sorted_insert_table_unit #(
   parameter int TABLE_DEPTH = sit_pkg::TableDepthDefault,
   parameter int TAG_BITS    = sit_pkg::TagBitsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sit_pkg::req_type req_data,
   output logic             rsp_strobe,
   output sit_pkg::rsp_type rsp_data
);
   import sit_pkg::*;

   localparam int IdxW = $clog2(TABLE_DEPTH);
   localparam int CntW = $clog2(TABLE_DEPTH + 1);
   localparam int QryW = (IdxW > RankWidth) ? IdxW : RankWidth;

   logic                          accept;
   cell_ctl_type                  ctl;
   logic [TABLE_DEPTH-1:0]        ge;
   logic [TABLE_DEPTH-1:0]        take_new;
   logic [TABLE_DEPTH-1:0]        left_ge;
   logic [TABLE_DEPTH-1:0]        cell_valid;
   logic [TABLE_DEPTH-1:0]        hit;
   logic signed [ScoreWidth-1:0]  score_q [TABLE_DEPTH];
   logic [TAG_BITS-1:0]           tag_q   [TABLE_DEPTH];

   logic [CntW-1:0]               count_ff, count_in;
   logic                          rsp_valid_ff;
   rsp_type                       rsp_ff, rsp_in;
   logic [IdxW-1:0]               placed_idx;
   logic                          dropped;
   logic                          full;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == CntW'(TABLE_DEPTH));

   assign ctl.ins_en = accept && (req_data.op == OP_INSERT);
   assign ctl.score  = req_data.score;
   assign ctl.tag    = req_data.tag;

   // cell chain
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      assign cell_valid[i] = (CntW'(i) < count_ff);
      assign hit[i]        = (QryW'(req_data.rank_query) == QryW'(i)) && cell_valid[i];

      if (i == 0) begin : g_head
         assign left_ge[i] = 1'b1;
         sit_cell #(
            .TAG_BITS (TAG_BITS)
         ) u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .cell_valid (cell_valid[i]),
            .left_ge    (left_ge[i]),
            .left_score (ctl.score),
            .left_tag   (ctl.tag[TAG_BITS-1:0]),
            .ge         (ge[i]),
            .take_new   (take_new[i]),
            .score_ff   (score_q[i]),
            .tag_ff     (tag_q[i])
         );
      end else begin : g_body
         assign left_ge[i] = ge[i-1];
         sit_cell #(
            .TAG_BITS (TAG_BITS)
         ) u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .cell_valid (cell_valid[i]),
            .left_ge    (left_ge[i]),
            .left_score (score_q[i-1]),
            .left_tag   (tag_q[i-1]),
            .ge         (ge[i]),
            .take_new   (take_new[i]),
            .score_ff   (score_q[i]),
            .tag_ff     (tag_q[i])
         );
      end
   end

   // rank of the landing cell; no landing cell means dropped as last
   always_comb begin
      placed_idx = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (take_new[i]) begin
            placed_idx = placed_idx | IdxW'(i);
         end
      end
   end
   assign dropped = !(|take_new);

   // response and fill count
   always_comb begin
      rsp_in   = '0;
      count_in = count_ff;
      if (req_data.op == OP_INSERT) begin
         if (dropped) begin
            rsp_in.placed_rank = CountWidth'(TABLE_DEPTH);
         end else begin
            rsp_in.placed_rank = CountWidth'(placed_idx);
            rsp_in.kept        = 1'b1;
            rsp_in.evicted     = full;
            if (!full) begin
               count_in = count_ff + CntW'(1);
            end
         end
      end else begin
         rsp_in.read_valid = |hit;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (hit[i]) begin
               rsp_in.read_score = rsp_in.read_score | score_q[i];
               rsp_in.read_tag   = rsp_in.read_tag | TagWidth'(tag_q[i]);
            end
         end
      end
      rsp_in.fill_count = CountWidth'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

@@ rtl/sit_checker.sv @@
// ----------------------------------------------------------------------------
// sit_checker
// Port-level checks for the sorted insert table: one response per request
// with fixed latency, and consistent insert/read flags.
// ----------------------------------------------------------------------------
module sit_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input sit_pkg::rsp_type rsp_data
);
   import sit_pkg::*;

   // every request answered on the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("request without response");

   // no response without a request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_strobe)
      else $error("response without request");

   // eviction only happens when the newcomer is kept
   a_evict_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.evicted) |-> rsp_data.kept)
      else $error("eviction with dropped entry");

   // a read response that hits a stored entry carries no insert flags
   a_read_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.read_valid) |-> (!rsp_data.kept && !rsp_data.evicted))
      else $error("read response with insert flags");

endmodule

bind sorted_insert_table_unit sit_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_insert_table_unit. A shadow copy of the
// score-ordered table predicts each response. Directed requests cover empty
// and partly filled reads, ties, extreme scores, a full table that drops or
// evicts, and reads past the fill count. Random traffic follows, run under
// several sender idle rates.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sit_pkg::*;

   localparam int TableDepth = TableDepthDefault;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   sorted_insert_table_unit uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // shadow of the table contents
   logic signed [ScoreWidth-1:0] shadow_scores [TableDepth];
   logic [TagWidth-1:0]          shadow_tags [TableDepth];
   int                           shadow_fill;

   rsp_type pending_rsps [$];
   int      error_count;
   int      n_inserts, n_reads, n_kept, n_evicted, n_dropped, n_read_valid;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      #1_000_000;
      $display("tb: errors");
      $finish;
   end

   // apply one request to the shadow table and return its response
   function automatic rsp_type table_predict(input req_type r);
      rsp_type                      o;
      logic signed [ScoreWidth-1:0] s;
      int                           pos;
      int                           last;
      o = '0;
      if (r.op == OP_INSERT) begin
         s = r.score;
         pos = 0;
         while (pos < shadow_fill && shadow_scores[pos] >= s) pos++;
         if (pos >= TableDepth) begin
            // newcomer would rank last in a full table
            o.placed_rank = CountWidth'(TableDepth);
         end else begin
            last = shadow_fill;
            if (shadow_fill >= TableDepth) begin
               o.evicted = 1'b1;
               last = TableDepth - 1;
            end else begin
               shadow_fill++;
            end
            for (int i = last; i > pos; i--) begin
               shadow_scores[i] = shadow_scores[i-1];
               shadow_tags[i]   = shadow_tags[i-1];
            end
            shadow_scores[pos] = s;
            shadow_tags[pos]   = r.tag;
            o.placed_rank = CountWidth'(pos);
            o.kept = 1'b1;
         end
      end else if (int'(r.rank_query) < shadow_fill) begin
         o.read_score = shadow_scores[r.rank_query];
         o.read_tag   = shadow_tags[r.rank_query];
         o.read_valid = 1'b1;
      end
      o.fill_count = CountWidth'(shadow_fill);
      return o;
   endfunction

   function automatic void check_field(input string fname, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      end
   endfunction

   // response check first, then capture of an accepted request
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (pending_rsps.size() == 0) begin
               error_count++;
               $display("%0t: response with none expected, expected nothing, actual %h",
                        $time, rsp_data);
            end else begin
               want = pending_rsps.pop_front();
               check_field("placed_rank", 64'(want.placed_rank), 64'(rsp_data.placed_rank));
               check_field("kept",        64'(want.kept),        64'(rsp_data.kept));
               check_field("evicted",     64'(want.evicted),     64'(rsp_data.evicted));
               check_field("fill_count",  64'(want.fill_count),  64'(rsp_data.fill_count));
               check_field("read_score",  64'(want.read_score),  64'(rsp_data.read_score));
               check_field("read_tag",    64'(want.read_tag),    64'(rsp_data.read_tag));
               check_field("read_valid",  64'(want.read_valid),  64'(rsp_data.read_valid));
            end
         end
         if (start && !busy) begin
            want = table_predict(req_data);
            pending_rsps.push_back(want);
            if (req_data.op == OP_INSERT) begin
               n_inserts++;
               n_kept    += want.kept;
               n_evicted += want.evicted;
               n_dropped += !want.kept;
            end else begin
               n_reads++;
               n_read_valid += want.read_valid;
            end
         end
      end
   end

   function automatic req_type make_insert(input logic signed [ScoreWidth-1:0] s,
                                           input logic [TagWidth-1:0] t);
      req_type r;
      r = '0;
      r.op = OP_INSERT;
      r.score = s;
      r.tag = t;
      r.rank_query = RankWidth'($urandom);
      return r;
   endfunction

   function automatic req_type make_read(input logic [RankWidth-1:0] q);
      req_type r;
      r.op = OP_READ;
      r.score = ScoreWidth'($urandom);
      r.tag = {$urandom, $urandom};
      r.rank_query = q;
      return r;
   endfunction

   // score mix that keeps ties and near-last scores common
   function automatic logic signed [ScoreWidth-1:0] pick_score();
      logic signed [ScoreWidth-1:0] s;
      s = ScoreWidth'($urandom);
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0: s = 16'sh8000;
               1: s = 16'sh7fff;
               2: s = '0;
               default: s = '1;
            endcase
         end
         1, 2: begin
            if (shadow_fill > 0) s = shadow_scores[$urandom_range(shadow_fill - 1)];
         end
         3, 4, 5: begin
            if (shadow_fill > 0)
               s = shadow_scores[shadow_fill - 1] + ScoreWidth'($urandom_range(8)) - 16'sd4;
         end
         default: ;
      endcase
      return s;
   endfunction

   // send one request, idling first at the given rate; start stays high after
   task automatic send_request(input req_type r, input int idle_pct);
      req_type junk;
      while ($urandom_range(99) < idle_pct) begin
         junk.op         = op_type'($urandom_range(1));
         junk.score      = ScoreWidth'($urandom);
         junk.tag        = {$urandom, $urandom};
         junk.rank_query = RankWidth'($urandom);
         @(negedge clock);
         start    <= 1'b0;
         req_data <= junk;
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // empty reads, extreme scores, ties and reads past the fill count
   task automatic test_partial_table();
      send_request(make_read(4'd0), 0);
      send_request(make_read(4'd15), 0);
      send_request(make_insert(16'sh7fff, '1), 0);
      send_request(make_insert(16'sh8000, '0), 0);
      send_request(make_insert(16'sh7fff, 64'h0123_4567_89ab_cdef), 0);
      send_request(make_insert(16'sh0000, {$urandom, $urandom}), 0);
      send_request(make_insert(-16'sd1, {$urandom, $urandom}), 0);
      send_request(make_read(4'd0), 0);
      send_request(make_read(4'd1), 0);
      send_request(make_read(4'd4), 0);
      send_request(make_read(4'd5), 0);
      send_request(make_read(4'd15), 0);
   endtask

   // fill up, then drop a last-ranking newcomer and evict for a high one
   task automatic test_full_table();
      repeat (TableDepth - 5)
         send_request(make_insert(ScoreWidth'($urandom), {$urandom, $urandom}), 0);
      send_request(make_insert(16'sh8000, {$urandom, $urandom}), 0);
      send_request(make_insert(16'sh7fff, {$urandom, $urandom}), 0);
      send_request(make_read(4'd15), 0);
      send_request(make_read(4'd0), 0);
   endtask

   // mixed inserts and reads
   task automatic test_random_traffic(input int count, input int idle_pct);
      req_type r;
      repeat (count) begin
         if ($urandom_range(99) < 55) r = make_insert(pick_score(), {$urandom, $urandom});
         else r = make_read(RankWidth'($urandom));
         send_request(r, idle_pct);
      end
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      shadow_fill = 0;
      error_count = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_partial_table();
      test_full_table();
      test_random_traffic(500, 0);
      test_random_traffic(500, 72);
      test_random_traffic(500, 0);
      test_random_traffic(500, 38);

      @(negedge clock);
      start <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (pending_rsps.size() != 0) begin
         error_count++;
         $display("%0t: responses missing, expected %0d more, actual 0",
                  $time, pending_rsps.size());
      end

      $display("tb: %0d inserts (%0d kept, %0d evicted, %0d dropped as last)",
               n_inserts, n_kept, n_evicted, n_dropped);
      $display("tb: %0d reads (%0d hit a stored entry), %0d mismatches",
               n_reads, n_read_valid, error_count);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/sit_pkg.sv
rtl/sit_cell.sv
rtl/sorted_insert_table_unit.sv
rtl/sit_checker.sv
test/tb.sv
